>>> rtl/kect_pkg.sv
// Package for the keyed event counter table: sizes, request codes, item types.
// Used by the channel interfaces, the entry cell, the controller and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kect_pkg;

  // Table size and derived widths.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int RIDX_W  = 6;
  localparam int USED_W  = 7;
  localparam int CMP_W   = (FILL_W > RIDX_W) ? FILL_W : RIDX_W;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // Request codes; the fourth code is unused and is answered as rejected.
  typedef enum logic [1:0] {
    REQ_COUNT = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One table entry as it travels around the ring of cells.
  typedef struct packed {
    logic [7:0]  local_id;
    logic [7:0]  remote_id;
    logic [31:0] event_type;
    logic [31:0] count;
  } entry_t;

  // Input item.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        local_id;
    logic [7:0]        remote_id;
    logic [31:0]       event_type;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  // Result item.
  typedef struct packed {
    logic              accepted;
    logic              entry_valid;
    logic [7:0]        out_local_id;
    logic [7:0]        out_remote_id;
    logic [31:0]       out_type;
    logic [31:0]       out_count;
    logic [USED_W-1:0] used_entries;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/kect_in_if.sv
// Request channel of the keyed event counter table: valid, ready and one item.
// Depends on kect_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

interface kect_in_if import kect_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/kect_out_if.sv
// Result channel of the keyed event counter table: valid, ready and one item.
// Depends on kect_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

interface kect_out_if import kect_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/kect_cell.sv
// One cell of the entry ring: holds one table entry and passes it on when the ring turns.
// Depends on kect_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module kect_cell import kect_pkg::*; (
  input  wire logic   clk,
  input  wire logic   shift_en,
  input  wire entry_t entry_in,
  output entry_t      entry_out
);

  entry_t entry_r;

  // The entry moves one cell toward the head on every cycle in which shift_en is set.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= entry_in;
    end
  end

  assign entry_out = entry_r;

endmodule

`default_nettype wire

>>> rtl/kect_ctrl.sv
// Controller of the keyed event counter table: handshakes, fill level, and the
// head of the ring where entries are matched, updated, appended and read.
// Depends on kect_pkg and the two channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module kect_ctrl import kect_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kect_in_if.sink     in_ch,
  kect_out_if.source  out_ch,
  input  wire entry_t head,
  output entry_t      wrap,
  output logic        shift_en
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              hit_r, hit_nxt;
  req_t              req_r, req_nxt;
  rsp_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_data_r, out_data_nxt;

  logic [CMP_W-1:0]  step_ext;
  logic [CMP_W-1:0]  fill_ext;
  logic [CMP_W-1:0]  ridx_ext;
  logic              in_used;
  logic              key_match;
  logic [31:0]       cnt_inc;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Compare the entry now at the head of the ring with the request key.
  assign step_ext  = CMP_W'(step_r);
  assign fill_ext  = CMP_W'(fill_r);
  assign ridx_ext  = CMP_W'(req_r.read_index);
  assign in_used   = (step_ext < fill_ext);
  assign key_match = (head.local_id == req_r.local_id) &&
                     (head.remote_id == req_r.remote_id) &&
                     (head.event_type == req_r.event_type);
  assign cnt_inc   = (head.count == CNT_MAX) ? head.count : head.count + 32'd1;

  // Next state, head update and result assembly.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    fill_nxt      = fill_r;
    hit_nxt       = hit_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wrap          = head;
    shift_en      = 1'b0;
    in_ch.ready   = (state_r == ST_IDLE);

    // The result register drains independently of the table.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt  = in_ch.data;
          res_nxt  = '0;
          hit_nxt  = 1'b0;
          step_nxt = '0;
          case (in_ch.data.req_type)
            REQ_COUNT, REQ_READ: begin
              state_nxt = ST_SCAN;
            end
            REQ_CLEAR: begin
              fill_nxt            = '0;
              res_nxt.accepted    = 1'b1;
              state_nxt           = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        shift_en = 1'b1;
        if (req_r.req_type == REQ_COUNT) begin
          // First used entry with a matching key takes the increment.
          if (!hit_r && in_used && key_match) begin
            wrap.count        = cnt_inc;
            hit_nxt           = 1'b1;
            res_nxt.accepted  = 1'b1;
            res_nxt.out_count = cnt_inc;
          end else if (!hit_r && (step_ext == fill_ext)) begin
            // The first free slot takes the new key; never reached when full.
            wrap.local_id     = req_r.local_id;
            wrap.remote_id    = req_r.remote_id;
            wrap.event_type   = req_r.event_type;
            wrap.count        = 32'd1;
            fill_nxt          = fill_r + FILL_W'(1);
            hit_nxt           = 1'b1;
            res_nxt.accepted  = 1'b1;
            res_nxt.out_count = 32'd1;
          end
        end else begin
          // Read: capture the entry as it passes the head.
          res_nxt.accepted = 1'b1;
          if (in_used && (step_ext == ridx_ext)) begin
            res_nxt.entry_valid   = 1'b1;
            res_nxt.out_local_id  = head.local_id;
            res_nxt.out_remote_id = head.remote_id;
            res_nxt.out_type      = head.event_type;
            res_nxt.out_count     = head.count;
          end
        end
        if (step_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end

      ST_DONE: begin
        // Hand the result over once the result register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = res_r;
          out_data_nxt.used_entries = USED_W'(fill_r);
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/keyed_event_counter_table.sv
// Keyed event counter table.
// Requests arrive on in_ch (valid/ready, one item per handshake): count an event
// key, read the entry at an index, or clear the table. Each request yields one
// result item on out_ch (valid/ready).
// Entries live in a ring of ENTRIES cells. A count or read request turns the ring
// once, one cell per cycle, and every entry passes the head where it is matched,
// incremented, appended or captured; the ring ends where it started.
// A count or read result passes the scan state, the done state and the output
// register before it is valid; clear and unknown requests skip the scan.
// Requests are handled one at a time: in_ch is ready only while the controller is
// idle, so a new request waits until the last result has left the controller.
// A finished result waits in the output register; the next request is accepted
// meanwhile, and its result waits in the controller until the register frees.
// A stalled receiver therefore holds at most one further request back.
// Reset (synchronous, active low) empties the table by zeroing the fill level
// and drops any pending result; the entry cells themselves are not cleared.
// Depends on kect_pkg, kect_in_if, kect_out_if, kect_cell and kect_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module keyed_event_counter_table import kect_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kect_in_if.sink    in_ch,
  kect_out_if.source out_ch
);

  entry_t cell_q [ENTRIES];
  entry_t wrap;
  logic   shift_en;

  // Controller sits at the head of the ring.
  kect_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .head     (cell_q[0]),
    .wrap     (wrap),
    .shift_en (shift_en)
  );

  // Ring of entry cells; the last cell is fed from the head via the controller.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    if (k == ENTRIES - 1) begin : g_tail
      kect_cell u_cell (
        .clk       (clk),
        .shift_en  (shift_en),
        .entry_in  (wrap),
        .entry_out (cell_q[k])
      );
    end else begin : g_body
      kect_cell u_cell (
        .clk       (clk),
        .shift_en  (shift_en),
        .entry_in  (cell_q[k+1]),
        .entry_out (cell_q[k])
      );
    end
  end

endmodule

`default_nettype wire

>>> bench/kect_checker.sv
// Checker for the keyed event counter table: watches both channels, predicts each result.
// Compares every result field by field against the oldest prediction still outstanding.
// Depends on kect_pkg, kect_in_if and kect_out_if.
`timescale 1ns / 1ps

module kect_checker import kect_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  kect_in_if        req_mon,
  kect_out_if       rsp_mon,
  output int        fail_count,
  output int        pending,
  output int        checked_count,
  output int        full_count
);

  // Shadow copy of the table.
  logic [7:0]  tbl_local  [ENTRIES];
  logic [7:0]  tbl_remote [ENTRIES];
  logic [31:0] tbl_type   [ENTRIES];
  logic [31:0] tbl_count  [ENTRIES];
  int          used_cnt;

  rsp_t expected_q [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    full_count    = 0;
    used_cnt      = 0;
  end

  // Apply one request to the shadow table and return the result it must produce.
  function automatic rsp_t apply_request(req_t rq);
    rsp_t r;
    int   hit_at;
    r      = '0;
    hit_at = -1;
    case (rq.req_type)
      REQ_COUNT: begin
        for (int i = 0; i < used_cnt; i++) begin
          if (hit_at < 0 && tbl_local[i] == rq.local_id && tbl_remote[i] == rq.remote_id &&
              tbl_type[i] == rq.event_type)
            hit_at = i;
        end
        if (hit_at >= 0) begin
          // Existing key: the count sticks at its maximum.
          if (tbl_count[hit_at] != CNT_MAX)
            tbl_count[hit_at] = tbl_count[hit_at] + 32'd1;
          r.accepted  = 1'b1;
          r.out_count = tbl_count[hit_at];
        end else if (used_cnt < ENTRIES) begin
          tbl_local[used_cnt]  = rq.local_id;
          tbl_remote[used_cnt] = rq.remote_id;
          tbl_type[used_cnt]   = rq.event_type;
          tbl_count[used_cnt]  = 32'd1;
          used_cnt++;
          r.accepted  = 1'b1;
          r.out_count = 32'd1;
        end else begin
          // Table full and no match: the event is dropped.
          full_count++;
        end
      end
      REQ_READ: begin
        r.accepted = 1'b1;
        if (int'(rq.read_index) < used_cnt) begin
          r.entry_valid   = 1'b1;
          r.out_local_id  = tbl_local[rq.read_index];
          r.out_remote_id = tbl_remote[rq.read_index];
          r.out_type      = tbl_type[rq.read_index];
          r.out_count     = tbl_count[rq.read_index];
        end
      end
      REQ_CLEAR: begin
        used_cnt   = 0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.used_entries = used_cnt[USED_W-1:0];
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Record each accepted request, then match each accepted result.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst_n) begin
      expected_q.delete();
      used_cnt = 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(apply_request(req_mon.data));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (expected_q.size() == 0) begin
          $display("%0t ns: result arrived with no request outstanding: %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          checked_count++;
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
          check_field("out_local_id", 32'(want.out_local_id), 32'(got.out_local_id));
          check_field("out_remote_id", 32'(want.out_remote_id), 32'(got.out_remote_id));
          check_field("out_type", want.out_type, got.out_type);
          check_field("out_count", want.out_count, got.out_count);
          check_field("used_entries", 32'(want.used_entries), 32'(got.used_entries));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

>>> bench/tb_top.sv
// Top of the keyed event counter table bench: clock, reset, request stimulus and verdict.
// Prediction and comparison live in kect_checker, which runs beside the block.
// Depends on kect_pkg, kect_in_if, kect_out_if, kect_checker and keyed_event_counter_table.
`timescale 1ns / 1ps

module tb_top;
  import kect_pkg::*;

  localparam int ITEM_TARGET    = 2000;
  localparam int CALM_FROM      = 1800;
  localparam int QUIET_TAIL     = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE      = 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  kect_in_if  in_ch ();
  kect_out_if out_ch ();

  int   fail_count;
  int   pending;
  int   checked_count;
  int   full_count;
  int   sent;
  bit   idling;
  int   stall_left;
  int   quiet_cycles;
  req_t key_pool [POOL_SIZE];

  keyed_event_counter_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kect_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_ch),
    .rsp_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver side: ready drops for random bursts while idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_request(logic [1:0] code, logic [7:0] lid, logic [7:0] rid,
                                        logic [31:0] typ, logic [RIDX_W-1:0] idx);
    req_t r;
    r.req_type   = code;
    r.local_id   = lid;
    r.remote_id  = rid;
    r.event_type = typ;
    r.read_index = idx;
    return r;
  endfunction

  function automatic req_t random_fields(logic [1:0] code);
    return make_request(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        $urandom(), RIDX_W'($urandom_range(0, 63)));
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(req_t item);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    idling = (sent < CALM_FROM) && ((sent / 150) % 3 != 2);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Clear, then push more distinct keys than the table holds so it fills and rejects.
  task automatic fill_table();
    req_t last_key;
    req_t first_key;
    send_item(random_fields(REQ_CLEAR));
    for (int i = 0; i < ENTRIES + 4; i++) begin
      last_key = random_fields(REQ_COUNT);
      if (i == 0)
        first_key = last_key;
      send_item(last_key);
    end
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, RIDX_W'(ENTRIES - 1)));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd0));
    // The last key was rejected; a key still in the table keeps counting.
    send_item(last_key);
    send_item(first_key);
  endtask

  initial begin
    int   next_fill;
    int   next_drain;
    int   pick;
    int   slot;
    req_t item;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    sent         = 0;
    idling       = 1'b1;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = random_fields(REQ_COUNT);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, all-zero and all-one keys, partial matches, clear, bad code.
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd0));
    send_item(make_request(REQ_COUNT, 8'h00, 8'h00, 32'h0, 6'd0));
    send_item(make_request(REQ_COUNT, 8'h00, 8'h00, 32'h0, 6'd63));
    send_item(make_request(REQ_COUNT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    send_item(make_request(REQ_COUNT, 8'h00, 8'h00, 32'h1, 6'd0));
    send_item(make_request(REQ_COUNT, 8'h01, 8'h00, 32'h0, 6'd0));
    send_item(make_request(REQ_COUNT, 8'h00, 8'h01, 32'h0, 6'd0));
    send_item(make_request(REQ_COUNT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd0));
    send_item(make_request(REQ_READ, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd0));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd1));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd4));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd5));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd63));
    send_item(make_request(REQ_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd0));
    send_item(make_request(REQ_UNUSED, 8'h00, 8'h00, 32'h0, 6'd63));
    send_item(make_request(REQ_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd0));
    send_item(make_request(REQ_COUNT, 8'h00, 8'h00, 32'h0, 6'd0));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd0));
    send_item(make_request(REQ_READ, 8'h00, 8'h00, 32'h0, 6'd1));
    drain_results();

    // Random: mostly counts over a small pool of live keys, with reads and rare clears.
    next_fill  = 100;
    next_drain = 400;
    while (sent < ITEM_TARGET) begin
      if (sent >= next_fill) begin
        fill_table();
        next_fill += 500;
      end
      if (sent >= next_drain) begin
        drain_results();
        next_drain += 400;
      end
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 40) begin
        item            = key_pool[slot];
        item.read_index = RIDX_W'($urandom_range(0, 63));
      end else if (pick < 55) begin
        // Near miss: one key field differs from a live key.
        item = key_pool[slot];
        case ($urandom_range(0, 2))
          0:       item.local_id   = item.local_id ^ 8'(1 << $urandom_range(0, 7));
          1:       item.remote_id  = item.remote_id ^ 8'(1 << $urandom_range(0, 7));
          default: item.event_type = item.event_type ^ (32'd1 << $urandom_range(0, 31));
        endcase
      end else if (pick < 80) begin
        item           = random_fields(REQ_COUNT);
        key_pool[slot] = item;
      end else if (pick < 96) begin
        item = random_fields(REQ_READ);
        if ($urandom_range(0, 1) == 0)
          item.read_index = RIDX_W'($urandom_range(0, 15));
      end else if (pick < 97) begin
        item = random_fields(REQ_CLEAR);
      end else begin
        item = random_fields(REQ_UNUSED);
      end
      send_item(item);
    end

    drain_results();
    repeat (QUIET_TAIL) @(posedge clk);
    $display("covered %0d requests and %0d checked results, with %0d events turned away",
             sent, checked_count, full_count);
    $display("by a full table, plus reads past the used entries, clears and unused codes");
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> keyed_event_counter_table.f
rtl/kect_pkg.sv
rtl/kect_in_if.sv
rtl/kect_out_if.sv
rtl/kect_cell.sv
rtl/kect_ctrl.sv
rtl/keyed_event_counter_table.sv
bench/kect_checker.sv
bench/tb_top.sv
